>>> hw/rtl/led_status_pattern_generator_macros.svh
// assertion helpers for the status led generator
`ifndef LED_STATUS_PATTERN_GENERATOR_MACROS_SVH
`define LED_STATUS_PATTERN_GENERATOR_MACROS_SVH

// checked only out of reset, on the rising edge of clk
`define LSPG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// also checked while reset is asserted
`define LSPG_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/lspg_pkg.sv
package lspg_pkg;

  typedef enum logic [2:0] {
    KIND_TICK     = 3'd0,
    KIND_DCD_ON   = 3'd1,
    KIND_DCD_OFF  = 3'd2,
    KIND_TX_ON    = 3'd3,
    KIND_TX_OFF   = 3'd4,
    KIND_SET_MODE = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    LINK_NONE = 2'd0,
    LINK_USB  = 2'd1,
    LINK_BT   = 2'd2
  } link_t;

  typedef enum logic [1:0] {
    PH_UP   = 2'd0,
    PH_DOWN = 2'd1,
    PH_WAIT = 2'd2
  } phase_kind_t;

  typedef enum logic [1:0] {
    FD_UP   = 2'd0,
    FD_ON   = 2'd1,
    FD_DOWN = 2'd2,
    FD_OFF  = 2'd3
  } fade_state_t;

  localparam int BlueW = 14;
  localparam int FadeW = 12;
  localparam int StepW = 10;
  localparam int PhaseW = 4;
  localparam int FadeStepW = 4;
  localparam int LevelW = 11;

  localparam logic [StepW-1:0] NcWaitLast = 10'd849;
  localparam logic [StepW-1:0] BtWaitLast = 10'd439;
  localparam logic [StepW-1:0] UsbWaitLast = 10'd379;
  localparam logic [LevelW-1:0] NcHoldLevel = 11'd2000;
  localparam logic [FadeStepW-1:0] FadeTop = 4'd9;

  typedef struct packed {
    phase_kind_t             kind;
    logic [StepW-1:0]        limit;
    logic [LevelW-1:0]       level;
    logic [StepW-1:0]        next;
  } phase_desc_t;

  typedef struct packed {
    logic  tick;
    logic  set_mode;
    link_t link;
  } blue_cmd_t;

  typedef struct packed {
    logic tick;
    logic on;
    logic off;
  } fade_cmd_t;

  function automatic logic [BlueW-1:0] sine_at(input logic [StepW-1:0] idx);
    logic [BlueW-1:0] v;
    v = 14'd9999;
    if (idx < 10'd9) begin
      unique case (idx[3:0])
        4'd0: v = 14'd1564;
        4'd1: v = 14'd3090;
        4'd2: v = 14'd4540;
        4'd3: v = 14'd5878;
        4'd4: v = 14'd7071;
        4'd5: v = 14'd8090;
        4'd6: v = 14'd8910;
        4'd7: v = 14'd9510;
        4'd8: v = 14'd9877;
        default: v = 14'd9999;
      endcase
    end
    return v;
  endfunction

  // sine table scaled by one third, rounded down
  function automatic logic [FadeW-1:0] sine_third(input logic [FadeStepW-1:0] idx);
    logic [FadeW-1:0] v;
    unique case (idx)
      4'd0: v = 12'd521;
      4'd1: v = 12'd1030;
      4'd2: v = 12'd1513;
      4'd3: v = 12'd1959;
      4'd4: v = 12'd2357;
      4'd5: v = 12'd2696;
      4'd6: v = 12'd2970;
      4'd7: v = 12'd3170;
      4'd8: v = 12'd3292;
      default: v = 12'd3333;
    endcase
    return v;
  endfunction

  function automatic logic [PhaseW-1:0] phase_count(input link_t link);
    logic [PhaseW-1:0] n;
    unique case (link)
      LINK_USB: n = 4'd9;
      LINK_BT:  n = 4'd6;
      default:  n = 4'd4;
    endcase
    return n;
  endfunction

  function automatic phase_desc_t mk_desc(input phase_kind_t kind,
                                         input logic [StepW-1:0] limit,
                                         input logic [LevelW-1:0] level,
                                         input logic [StepW-1:0] next);
    phase_desc_t d;
    d.kind = kind;
    d.limit = limit;
    d.level = level;
    d.next = next;
    return d;
  endfunction

  function automatic phase_desc_t phase_desc(input link_t link,
                                             input logic [PhaseW-1:0] phase);
    phase_desc_t d;
    d = mk_desc(PH_WAIT, '0, '0, '0);
    unique case (link)
      LINK_USB: begin
        unique case (phase)
          4'd0, 4'd3, 4'd6: d = mk_desc(PH_UP, 10'd9, '0, 10'd9);
          4'd1, 4'd4, 4'd7: d = mk_desc(PH_DOWN, '0, '0, '0);
          4'd2: d = mk_desc(PH_WAIT, 10'd39, '0, '0);
          4'd5: d = mk_desc(PH_WAIT, 10'd19, '0, '0);
          default: d = mk_desc(PH_WAIT, UsbWaitLast, '0, '0);
        endcase
      end
      LINK_BT: begin
        unique case (phase)
          4'd0, 4'd3: d = mk_desc(PH_UP, 10'd9, '0, 10'd9);
          4'd1, 4'd4: d = mk_desc(PH_DOWN, '0, '0, '0);
          4'd2: d = mk_desc(PH_WAIT, 10'd19, '0, '0);
          default: d = mk_desc(PH_WAIT, BtWaitLast, '0, '0);
        endcase
      end
      default: begin
        unique case (phase)
          4'd0: d = mk_desc(PH_UP, 10'd49, '0, '0);
          4'd1: d = mk_desc(PH_WAIT, 10'd49, NcHoldLevel, 10'd49);
          4'd2: d = mk_desc(PH_DOWN, '0, '0, '0);
          default: d = mk_desc(PH_WAIT, NcWaitLast, '0, '0);
        endcase
      end
    endcase
    return d;
  endfunction

endpackage

>>> hw/rtl/lspg_blue.sv
module lspg_blue (
  input  logic                    clk,
  input  logic                    rst,
  input  lspg_pkg::blue_cmd_t     cmd,
  output logic [lspg_pkg::BlueW-1:0] duty,
  output logic                    enable
);
  import lspg_pkg::*;

  link_t              link, link_next;
  logic [PhaseW-1:0]  phase, phase_next;
  logic [StepW-1:0]   step, step_next;
  logic               enable_next;

  logic [PhaseW-1:0]  count;
  logic [PhaseW-1:0]  phase_inc;
  logic [PhaseW-1:0]  phase_wrap;
  phase_desc_t        desc;
  logic [BlueW-1:0]   sine;
  logic [15:0]        ramp;

  always_ff @(posedge clk) begin
    if (rst) begin
      link <= LINK_NONE;
      phase <= '0;
      step <= '0;
      enable <= 1'b0;
    end else begin
      link <= link_next;
      phase <= phase_next;
      step <= step_next;
      enable <= enable_next;
    end
  end

  always_comb begin
    count = phase_count(link);
    desc = phase_desc(link, phase);
    phase_inc = phase + 4'd1;
    phase_wrap = (phase_inc == count) ? '0 : phase_inc;
    sine = sine_at(step);
    // step * 40 as two shifts
    ramp = {1'b0, step, 5'b0} + {3'b0, step, 3'b0};

    if (phase >= count) begin
      duty = '0;
    end else if (desc.kind == PH_WAIT) begin
      duty = BlueW'(desc.level);
    end else begin
      unique case (link)
        LINK_USB: duty = sine;
        LINK_BT:  duty = {1'b0, sine[BlueW-1:1]};
        default:  duty = ramp[BlueW-1:0];
      endcase
    end

    link_next = link;
    phase_next = phase;
    step_next = step;
    enable_next = enable;

    if (cmd.set_mode) begin
      link_next = (cmd.link == LINK_USB || cmd.link == LINK_BT) ? cmd.link : LINK_NONE;
      phase_next = '0;
      step_next = '0;
      enable_next = 1'b1;
    end else if (cmd.tick) begin
      if (phase >= count) begin
        phase_next = '0;
        step_next = '0;
      end else if (desc.kind == PH_DOWN) begin
        if (step == '0) phase_next = phase_wrap;
        else step_next = step - 10'd1;
      end else begin
        if (step == desc.limit) begin
          phase_next = phase_wrap;
          step_next = desc.next;
        end else begin
          step_next = step + 10'd1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/lspg_fade.sv
module lspg_fade (
  input  logic                       clk,
  input  logic                       rst,
  input  lspg_pkg::fade_cmd_t        cmd,
  output logic [lspg_pkg::FadeW-1:0] duty,
  output logic                       enable_next
);
  import lspg_pkg::*;

  fade_state_t           state, state_next;
  logic [FadeStepW-1:0]  step, step_next;
  logic                  enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FD_OFF;
      step <= FadeTop;
      enable <= 1'b0;
    end else begin
      state <= state_next;
      step <= step_next;
      enable <= enable_next;
    end
  end

  always_comb begin
    duty = (state == FD_OFF) ? '0 : sine_third(step);
    state_next = state;
    step_next = step;
    enable_next = enable;

    if (cmd.tick) begin
      unique case (state)
        FD_UP: begin
          if (step >= FadeTop) state_next = FD_ON;
          else step_next = step + 4'd1;
        end
        FD_DOWN: begin
          if (step == '0) begin
            state_next = FD_OFF;
            enable_next = 1'b0;
          end else begin
            step_next = step - 4'd1;
          end
        end
        default: ;
      endcase
    end else if (cmd.on) begin
      if (state == FD_OFF) enable_next = 1'b1;
      state_next = FD_UP;
    end else if (cmd.off) begin
      if (state != FD_OFF) state_next = FD_DOWN;
    end
  end

endmodule

>>> hw/rtl/led_status_pattern_generator.sv
// Status LED generator: takes one event per cycle (ticks every 10 ms, carrier detect and
// transmit on/off, link mode changes) and for each tick returns the blue, green and red
// PWM compare values with the three PWM enables. Other events update state and return
// nothing. An event is held in an input register and then processed; a tick's result
// goes into an output register, so a result is offered once its tick has passed the input
// register and the output register, and one event per cycle is sustained while the result
// side keeps up; a stalled result holds off only the next tick in the input register.
module led_status_pattern_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [1:0] link_mode, [7:2] zero
  input  logic [2:0]  s_tuser,   // [2:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // [13:0] blue_duty, [25:14] green_duty, [37:26] red_duty,
                                 // [38] blue_enable, [39] green_enable, [40] red_enable,
                                 // [47:41] zero
);
  import lspg_pkg::*;

  logic        in_valid;
  kind_t       in_kind;
  link_t       in_link;
  logic        advance;
  logic        is_tick;

  blue_cmd_t   blue_cmd;
  fade_cmd_t   green_cmd;
  fade_cmd_t   red_cmd;

  logic [BlueW-1:0] blue_duty;
  logic [FadeW-1:0] green_duty;
  logic [FadeW-1:0] red_duty;
  logic             blue_enable;
  logic             green_enable;
  logic             red_enable;

  assign is_tick = (in_kind == KIND_TICK);
  assign advance = in_valid && (!is_tick || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind <= kind_t'(s_tuser);
      in_link <= link_t'(s_tdata[1:0]);
    end
  end

  always_comb begin
    blue_cmd.tick = advance && is_tick;
    blue_cmd.set_mode = advance && (in_kind == KIND_SET_MODE);
    blue_cmd.link = in_link;
    green_cmd.tick = advance && is_tick;
    green_cmd.on = advance && (in_kind == KIND_DCD_ON);
    green_cmd.off = advance && (in_kind == KIND_DCD_OFF);
    red_cmd.tick = advance && is_tick;
    red_cmd.on = advance && (in_kind == KIND_TX_ON);
    red_cmd.off = advance && (in_kind == KIND_TX_OFF);
  end

  lspg_blue u_blue (
    .clk    (clk),
    .rst    (rst),
    .cmd    (blue_cmd),
    .duty   (blue_duty),
    .enable (blue_enable)
  );

  lspg_fade u_green (
    .clk         (clk),
    .rst         (rst),
    .cmd         (green_cmd),
    .duty        (green_duty),
    .enable_next (green_enable)
  );

  lspg_fade u_red (
    .clk         (clk),
    .rst         (rst),
    .cmd         (red_cmd),
    .duty        (red_duty),
    .enable_next (red_enable)
  );

  // result register, loaded by a tick transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && is_tick) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_tick) begin
      m_tdata <= {7'b0, red_enable, green_enable, blue_enable,
                  red_duty, green_duty, blue_duty};
    end
  end

endmodule

>>> hw/rtl/lspg_checker.sv
module lspg_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic [2:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);
`include "led_status_pattern_generator_macros.svh"

  `LSPG_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
  `LSPG_ASSERT(a_blue_range, m_tvalid |-> m_tdata[13:0] <= 14'd9999, "blue duty out of range")
  `LSPG_ASSERT(a_fade_range, m_tvalid |-> m_tdata[25:14] <= 12'd3333 && m_tdata[37:26] <= 12'd3333, "fade duty out of range")
  `LSPG_ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> !m_tvalid, "result valid right after reset")

endmodule

bind led_status_pattern_generator lspg_checker u_lspg_checker (.*);
